FILE: rtl/core/chp_pkg.sv
// ----------------------------------------------------------------------------
// chp_pkg
// Shared types and constants of the CBOR item head parser: result kinds,
// parse phases, major type and minor value codes, and the queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package chp_pkg;

  typedef enum logic [1:0] {
    KIND_ITEM    = 2'd0,
    KIND_TAG     = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_MISSING = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_INITIAL  = 2'd0,
    PH_ARGUMENT = 2'd1,
    PH_PAYLOAD  = 2'd2
  } phase_e;

  localparam logic [2:0] MAJOR_UINT = 3'd0;
  localparam logic [2:0] MAJOR_NINT = 3'd1;
  localparam logic [2:0] MAJOR_BSTR = 3'd2;
  localparam logic [2:0] MAJOR_TSTR = 3'd3;
  localparam logic [2:0] MAJOR_TAG  = 3'd6;

  localparam logic [4:0] MINOR_DIRECT_MAX = 5'h17;
  localparam logic [4:0] MINOR_ARG1       = 5'h18;
  localparam logic [4:0] MINOR_ARG2       = 5'h19;
  localparam logic [4:0] MINOR_ARG4       = 5'h1A;
  localparam logic [4:0] MINOR_ARG8       = 5'h1B;
  localparam logic [4:0] MINOR_RSVD_LO    = 5'h1C;
  localparam logic [4:0] MINOR_RSVD_HI    = 5'h1E;
  localparam logic [4:0] MINOR_INDEF      = 5'h1F;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  major_type;
    logic [4:0]  minor_value;
    logic [63:0] arg_value;
    logic        invalid;
    logic [7:0]  head_bytes;
    logic [7:0]  tag_count;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } res_t;

  // one word per accepted byte that yields results: a head or payload result and/or item missing
  typedef struct packed {
    logic       first_vld;
    res_t       first;
    logic       miss_vld;
    logic [7:0] miss_bytes;
    logic [7:0] miss_tags;
  } entry_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbor_item_head_parser_unit.sv
// ----------------------------------------------------------------------------
// cbor_item_head_parser_unit
// CBOR head parser: decodes initial bytes and arguments, reports tag and item
// heads, passes definite string payload through and flags a cut-off item.
// ----------------------------------------------------------------------------
//  channel   | handshake               | fields
//  ----------+-------------------------+-------------------------------------
//  input     | in_valid_i / in_stall_o | in_byte_i, buffer_end_i
//  output    | out_valid_o/out_stall_i | kind_o .. payload_last_o (9 fields)
//
//  one byte accepted per cycle while the queue has room
//  a byte yields zero, one or two results; the second is sent after the first is taken
//  first result of a byte is registered in the queue, then in the sequencer, before it appears
//  output stall backs up the queue; in_stall_o rises only when it is full
//  reset clears parser state and queue at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module cbor_item_head_parser_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          buffer_end_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         kind_o,
  output logic [2:0]         major_type_o,
  output logic [4:0]         minor_value_o,
  output logic [63:0]        arg_value_o,
  output logic               invalid_o,
  output logic [7:0]         head_bytes_o,
  output logic [7:0]         tag_count_o,
  output logic [7:0]         payload_byte_o,
  output logic               payload_last_o
);
  import chp_pkg::*;

  logic   accept;
  logic   push;
  entry_t push_data;
  logic   full;
  logic   pop;
  entry_t pop_data;
  logic   empty;
  res_t   out_res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  chp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .buffer_end_i (buffer_end_i),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  chp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  chp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign kind_o         = out_res.kind;
  assign major_type_o   = out_res.major_type;
  assign minor_value_o  = out_res.minor_value;
  assign arg_value_o    = out_res.arg_value;
  assign invalid_o      = out_res.invalid;
  assign head_bytes_o   = out_res.head_bytes;
  assign tag_count_o    = out_res.tag_count;
  assign payload_byte_o = out_res.payload_byte;
  assign payload_last_o = out_res.payload_last;

endmodule

`default_nettype wire

FILE: rtl/core/chp_front.sv
// ----------------------------------------------------------------------------
// chp_front
// Byte classifier: splits initial bytes, gathers arguments, tracks tags and
// string payloads, and emits one queue word per byte that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module chp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          buffer_end_i,
  output logic               push_o,
  output chp_pkg::entry_t    push_data_o
);
  import chp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  major_q, major_d;
  logic [4:0]  minor_q, minor_d;
  logic [3:0]  arg_left_q, arg_left_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] pay_left_q, pay_left_d;
  logic [7:0]  chunk_q, chunk_d;
  logic [7:0]  tags_q, tags_d;

  entry_t      ent;
  logic [7:0]  chunk_inc;
  logic [7:0]  tags_inc;
  logic [2:0]  maj;
  logic [4:0]  mnr;
  logic [3:0]  left_new;
  logic [63:0] acc_new;
  logic [63:0] val;
  logic        head_done;
  logic        bad;
  logic        is_tag;

  always_comb begin
    phase_d    = phase_q;
    major_d    = major_q;
    minor_d    = minor_q;
    arg_left_d = arg_left_q;
    acc_d      = acc_q;
    pay_left_d = pay_left_q;
    chunk_d    = chunk_q;
    tags_d     = tags_q;
    ent        = '0;
    chunk_inc  = sat_inc(chunk_q);
    tags_inc   = sat_inc(tags_q);
    maj        = major_q;
    mnr        = minor_q;
    left_new   = arg_left_q;
    acc_new    = acc_q;
    val        = '0;
    head_done  = 1'b0;
    bad        = 1'b0;
    is_tag     = 1'b0;

    if (accept_i) begin
      if (phase_q == PH_PAYLOAD) begin
        pay_left_d               = pay_left_q - 64'd1;
        ent.first_vld            = 1'b1;
        ent.first.kind           = KIND_PAYLOAD;
        ent.first.payload_byte   = in_byte_i;
        ent.first.payload_last   = (pay_left_q == 64'd1);
        if (pay_left_q == 64'd1) begin
          phase_d = PH_INITIAL;
        end
      end else begin
        chunk_d = chunk_inc;
        if (phase_q == PH_ARGUMENT) begin
          acc_new = {acc_q[55:0], in_byte_i};
          if (arg_left_q != 4'd0) begin
            left_new = arg_left_q - 4'd1;
          end
        end else begin
          maj     = in_byte_i[7:5];
          mnr     = in_byte_i[4:0];
          acc_new = '0;
          case (mnr)
            MINOR_ARG1: left_new = 4'd1;
            MINOR_ARG2: left_new = 4'd2;
            MINOR_ARG4: left_new = 4'd4;
            MINOR_ARG8: left_new = 4'd8;
            default:    left_new = 4'd0;
          endcase
          major_d = maj;
          minor_d = mnr;
        end
        head_done  = (left_new == 4'd0);
        arg_left_d = left_new;
        acc_d      = acc_new;
        if (!head_done) begin
          phase_d = PH_ARGUMENT;
        end else begin
          if (mnr <= MINOR_DIRECT_MAX) begin
            val = {59'd0, mnr};
          end else if (mnr <= MINOR_ARG8) begin
            val = acc_new;
          end
          bad = (mnr >= MINOR_RSVD_LO && mnr <= MINOR_RSVD_HI) ||
                (mnr == MINOR_INDEF &&
                 (maj == MAJOR_UINT || maj == MAJOR_NINT || maj == MAJOR_TAG));
          is_tag                 = (maj == MAJOR_TAG);
          ent.first_vld          = 1'b1;
          ent.first.kind         = is_tag ? KIND_TAG : KIND_ITEM;
          ent.first.major_type   = maj;
          ent.first.minor_value  = mnr;
          ent.first.arg_value    = val;
          ent.first.invalid      = bad;
          ent.first.head_bytes   = chunk_inc;
          ent.first.tag_count    = tags_q;
          arg_left_d             = 4'd0;
          acc_d                  = '0;
          phase_d                = PH_INITIAL;
          if (is_tag) begin
            tags_d = tags_inc;
          end else begin
            tags_d  = '0;
            chunk_d = '0;
            if ((maj == MAJOR_BSTR || maj == MAJOR_TSTR) && mnr <= MINOR_ARG8 &&
                val != 64'd0) begin
              pay_left_d = val;
              phase_d    = PH_PAYLOAD;
            end
          end
        end
        ent.miss_vld   = buffer_end_i && (!head_done || is_tag);
        ent.miss_bytes = chunk_inc;
        ent.miss_tags  = is_tag ? tags_inc : tags_q;
      end
      if (buffer_end_i) begin
        phase_d    = PH_INITIAL;
        major_d    = '0;
        minor_d    = '0;
        arg_left_d = '0;
        acc_d      = '0;
        pay_left_d = '0;
        chunk_d    = '0;
        tags_d     = '0;
      end
    end
  end

  assign push_o      = ent.first_vld | ent.miss_vld;
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_INITIAL;
      major_q    <= '0;
      minor_q    <= '0;
      arg_left_q <= '0;
      acc_q      <= '0;
      pay_left_q <= '0;
      chunk_q    <= '0;
      tags_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      major_q    <= major_d;
      minor_q    <= minor_d;
      arg_left_q <= arg_left_d;
      acc_q      <= acc_d;
      pay_left_q <= pay_left_d;
      chunk_q    <= chunk_d;
      tags_q     <= tags_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/chp_fifo.sv
// ----------------------------------------------------------------------------
// chp_fifo
// Short word queue between the byte classifier and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module chp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire chp_pkg::entry_t  push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output chp_pkg::entry_t       pop_data_o,
  output logic                  empty_o
);
  import chp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/chp_back.sv
// ----------------------------------------------------------------------------
// chp_back
// Result sequencer: holds one queue word in a register and sends its head or
// payload result and then its item missing result on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module chp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  wire chp_pkg::entry_t  pop_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output chp_pkg::res_t         out_res_o
);
  import chp_pkg::*;

  entry_t ent_q;
  logic   first_pend_q, first_pend_d;
  logic   miss_pend_q, miss_pend_d;
  logic   out_take;
  logic   last_take;
  logic   load;
  res_t   miss_res;

  assign out_valid_o = first_pend_q | miss_pend_q;
  assign out_take    = out_valid_o && !out_stall_i;
  assign last_take   = out_take && (first_pend_q ? !miss_pend_q : 1'b1);
  assign load        = (!out_valid_o || last_take) && !empty_i;
  assign pop_o       = load;

  always_comb begin
    miss_res            = '0;
    miss_res.kind       = KIND_MISSING;
    miss_res.head_bytes = ent_q.miss_bytes;
    miss_res.tag_count  = ent_q.miss_tags;
    out_res_o           = first_pend_q ? ent_q.first : miss_res;
  end

  always_comb begin
    first_pend_d = first_pend_q;
    miss_pend_d  = miss_pend_q;
    if (out_take) begin
      if (first_pend_q) begin
        first_pend_d = 1'b0;
      end else begin
        miss_pend_d = 1'b0;
      end
    end
    if (load) begin
      first_pend_d = pop_data_i.first_vld;
      miss_pend_d  = pop_data_i.miss_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pend_q <= 1'b0;
      miss_pend_q  <= 1'b0;
    end else begin
      first_pend_q <= first_pend_d;
      miss_pend_q  <= miss_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= pop_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/chp_checker.sv
// ----------------------------------------------------------------------------
// chp_checker
// Port-level checks of the CBOR head parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [2:0]  major_type_o,
  input wire logic [4:0]  minor_value_o,
  input wire logic [63:0] arg_value_o,
  input wire logic        invalid_o,
  input wire logic [7:0]  head_bytes_o,
  input wire logic [7:0]  tag_count_o,
  input wire logic [7:0]  payload_byte_o,
  input wire logic        payload_last_o
);
  import chp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(arg_value_o) && $stable(payload_byte_o) && $stable(head_bytes_o))
    else $error("output word changed while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PAYLOAD |->
      major_type_o == 3'd0 && minor_value_o == 5'd0 && arg_value_o == 64'd0 &&
      !invalid_o && head_bytes_o == 8'd0 && tag_count_o == 8'd0)
    else $error("payload result carries head fields");

  a_head_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ITEM || kind_o == KIND_TAG) |->
      payload_byte_o == 8'd0 && !payload_last_o && head_bytes_o != 8'd0 &&
      ((kind_o == KIND_TAG) == (major_type_o == MAJOR_TAG)))
    else $error("head result inconsistent");

  a_missing_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_MISSING |->
      major_type_o == 3'd0 && minor_value_o == 5'd0 && arg_value_o == 64'd0 &&
      !invalid_o && payload_byte_o == 8'd0 && !payload_last_o &&
      head_bytes_o != 8'd0)
    else $error("item missing result inconsistent");

endmodule

bind cbor_item_head_parser_unit chp_checker u_chp_checker (.*);

`default_nettype wire
